// ----- sv/rtd_pkg.sv -----
// Shared types and constants for the relocation table decoder.
`timescale 1ns / 1ps

package rtd_pkg;

    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int QueueCountW = $clog2(QueueDepth + 1);

    localparam logic [31:0] HeaderLastIndex = 32'd3;
    localparam logic [31:0] OffsetStep      = 32'd254;
    localparam logic [31:0] SkipMarker      = 32'd1;

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_ACTIVE,
        RUN_STOPPED
    } run_status_t;

    typedef enum logic [1:0] {
        KIND_PATCH,
        KIND_DONE,
        KIND_ERROR
    } result_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_ODD,
        ERR_LIMIT,
        ERR_OVERRUN
    } error_code_t;

    typedef enum logic [1:0] {
        CFG_SECTION_END_LIMIT,
        CFG_TABLE_LENGTH,
        CFG_RELOCATION_BASE
    } cfg_index_t;

    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  offset;
        logic         enable;
        error_code_t  error;
    } result_t;

endpackage

// ----- sv/rtd_front.sv -----
// Front end: configuration registers, table byte decoding and result classification.
`timescale 1ns / 1ps

module rtd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_first,
    input  logic             q_full,
    output logic             push,
    output rtd_pkg::result_t push_data
);
    import rtd_pkg::*;

    logic [31:0] section_end_limit_reg;
    logic [31:0] table_length_reg;
    logic [31:0] relocation_base_reg;

    run_status_t status_reg, status_next;
    logic [31:0] byte_index_reg, byte_index_next;
    logic [31:0] running_offset_reg, running_offset_next;
    logic [23:0] header_shift_reg, header_shift_next;

    logic        go;
    logic [31:0] eff_index;
    logic [23:0] eff_shift;
    logic        is_header_end;
    logic [31:0] add_operand;
    logic [31:0] add_base;
    logic [31:0] add_step;
    logic [31:0] sum;
    logic        ev_empty, ev_header, tail, ev_overrun, body;
    logic        ev_end, ev_num, ev_odd, ev_limit, ev_patch, stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_end_limit_reg <= '0;
            table_length_reg      <= '0;
            relocation_base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SECTION_END_LIMIT: section_end_limit_reg <= cfg_data;
                CFG_TABLE_LENGTH:      table_length_reg      <= cfg_data;
                CFG_RELOCATION_BASE:   relocation_base_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign go = in_valid && in_ready && (in_first || (status_reg == RUN_ACTIVE));

    assign eff_index     = in_first ? '0 : byte_index_reg;
    assign eff_shift     = in_first ? '0 : header_shift_reg;
    assign is_header_end = (eff_index == HeaderLastIndex);
    assign add_operand   = is_header_end ? {eff_shift, in_byte} : {24'd0, in_byte};
    assign add_base      = is_header_end ? '0 : running_offset_reg;
    assign add_step      = (add_operand == SkipMarker) ? OffsetStep : add_operand;
    assign sum           = add_base + add_step;

    assign ev_empty   = go && in_first && (table_length_reg == '0);
    assign ev_header  = go && !ev_empty && (eff_index < HeaderLastIndex);
    assign tail       = go && !ev_empty && !(eff_index < HeaderLastIndex);
    assign ev_overrun = tail && !is_header_end && (eff_index >= table_length_reg);
    assign body       = tail && !ev_overrun;
    assign ev_end     = body && (add_operand == '0);
    assign ev_num     = body && (add_operand != '0) && (add_operand != SkipMarker);
    assign ev_odd     = ev_num && sum[0];
    assign ev_limit   = ev_num && !sum[0] && (sum > section_end_limit_reg);
    assign ev_patch   = ev_num && !sum[0] && !(sum > section_end_limit_reg);
    assign stop       = ev_empty || ev_overrun || ev_end || ev_odd || ev_limit;

    always_comb
    begin
        status_next = status_reg;
        if (go)
        begin
            status_next = stop ? RUN_STOPPED : RUN_ACTIVE;
        end
    end

    always_comb
    begin
        byte_index_next     = byte_index_reg;
        running_offset_next = running_offset_reg;
        header_shift_next   = header_shift_reg;
        push                = 1'b0;
        push_data.kind      = KIND_DONE;
        push_data.offset    = '0;
        push_data.enable    = 1'b0;
        push_data.error     = ERR_NONE;

        if (go && in_first)
        begin
            byte_index_next     = '0;
            running_offset_next = '0;
            header_shift_next   = '0;
        end
        if (ev_header)
        begin
            header_shift_next = {eff_shift[15:0], in_byte};
        end
        if (ev_header || body)
        begin
            byte_index_next = eff_index + 32'd1;
        end
        if (body && !ev_end)
        begin
            running_offset_next = sum;
        end

        if (ev_empty || ev_end)
        begin
            push = 1'b1;
        end
        else if (ev_overrun)
        begin
            push             = 1'b1;
            push_data.kind   = KIND_ERROR;
            push_data.offset = running_offset_reg;
            push_data.error  = ERR_OVERRUN;
        end
        else if (ev_odd)
        begin
            push             = 1'b1;
            push_data.kind   = KIND_ERROR;
            push_data.offset = sum;
            push_data.error  = ERR_ODD;
        end
        else if (ev_limit)
        begin
            push             = 1'b1;
            push_data.kind   = KIND_ERROR;
            push_data.offset = sum;
            push_data.error  = ERR_LIMIT;
        end
        else if (ev_patch)
        begin
            push             = 1'b1;
            push_data.kind   = KIND_PATCH;
            push_data.offset = sum;
            push_data.enable = (relocation_base_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg         <= RUN_IDLE;
            byte_index_reg     <= '0;
            running_offset_reg <= '0;
            header_shift_reg   <= '0;
        end
        else
        begin
            status_reg         <= status_next;
            byte_index_reg     <= byte_index_next;
            running_offset_reg <= running_offset_next;
            header_shift_reg   <= header_shift_next;
        end
    end

endmodule

// ----- sv/rtd_queue.sv -----
// Short result queue between the decoding front end and the output stage.
`timescale 1ns / 1ps

module rtd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rtd_pkg::result_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output rtd_pkg::result_t pop_data
);
    import rtd_pkg::*;

    result_t                entries_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCountW-1:0] count_reg, count_next;

    assign full      = (count_reg == QueueCountW'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QueuePtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QueueCountW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - QueueCountW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/rtd_back.sv -----
// Back end: output register that presents queued results on the master stream.
`timescale 1ns / 1ps

module rtd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  rtd_pkg::result_t q_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rtd_pkg::result_t out_data
);
    import rtd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop = q_not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/relocation_table_decoder.sv -----
// Top level of the relocation table decoder with stream ports and configuration port.
// Path: a result is written into the result queue when its byte is accepted and is then
// registered in the output register, which presents it on the master side.
// Throughput: one table byte per cycle; the slave side stalls only while the
// four-entry result queue is full.
// Reset: asynchronous and active low; clears the configuration registers, the
// decoder state (idle, awaiting a first byte), the queue and the output valid flag.
`timescale 1ns / 1ps

module relocation_table_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] table_byte
    input  logic        s_axis_tuser,   // [0] first_of_table
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] patch_offset, [32] patch_enable,
                                        // [34:33] error_code, [39:35] zero
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);
    import rtd_pkg::*;

    logic    push;
    result_t push_data;
    logic    q_full;
    logic    pop;
    logic    q_not_empty;
    result_t q_data;
    result_t out_data;

    rtd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_first  (s_axis_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    rtd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (out_data)
    );

    assign m_axis_tdata = {5'd0, out_data.error, out_data.enable, out_data.offset};
    assign m_axis_tuser = out_data.kind;

endmodule
